// ===== rtl/close_payload_validator_core_assert.svh =====
// Assertion macros for the checker file.
`ifndef CLOSE_PAYLOAD_VALIDATOR_CORE_ASSERT_SVH
`define CLOSE_PAYLOAD_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CPV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpv assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CPV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpv assertion failed");

`endif

// ===== rtl/cpv_pkg.sv =====
`default_nettype none
package cpv_pkg;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_PROTO_ERR,
    STATUS_DATA_ERR
  } status_t;

  // lowest legal code point of the sequence under assembly
  localparam logic [1:0] MINC_NONE = 2'd0;
  localparam logic [1:0] MINC_2B   = 2'd1;
  localparam logic [1:0] MINC_3B   = 2'd2;
  localparam logic [1:0] MINC_4B   = 2'd3;

  localparam logic [15:0] CODE_MIN_A = 16'd1000;
  localparam logic [15:0] CODE_MAX_A = 16'd1003;
  localparam logic [15:0] CODE_MIN_B = 16'd1007;
  localparam logic [15:0] CODE_MAX_B = 16'd1014;
  localparam logic [15:0] CODE_MIN_C = 16'd3000;
  localparam logic [15:0] CODE_MAX_C = 16'd4999;

  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;

  typedef struct packed {
    logic [1:0]  byte_position;
    logic [15:0] code_value;
    logic        code_bad;
    logic [20:0] partial_codepoint;
    logic [1:0]  bytes_pending;
    logic [1:0]  minimum_class;
    logic        text_bad;
  } state_t;

  localparam state_t STATE_RESET = '0;

  typedef struct packed {
    status_t     status;
    logic        code_present;
    logic [15:0] close_code;
  } result_t;

  function automatic logic code_allowed(input logic [15:0] c);
    code_allowed = (c >= CODE_MIN_A && c <= CODE_MAX_A) ||
                   (c >= CODE_MIN_B && c <= CODE_MAX_B) ||
                   (c >= CODE_MIN_C && c <= CODE_MAX_C);
  endfunction

  function automatic logic [20:0] class_min(input logic [1:0] cls);
    case (cls)
      MINC_NONE: class_min = 21'h000000;
      MINC_2B:   class_min = 21'h000080;
      MINC_3B:   class_min = 21'h000800;
      MINC_4B:   class_min = 21'h010000;
      default:   class_min = 21'h000000;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cpv_step.sv =====
`default_nettype none
// One item's update of the decoder state, plus the verdict on the last item.
module cpv_step (
  input  wire logic [7:0]      data_byte,
  input  wire logic            empty_payload,
  input  wire logic            last_byte,
  input  wire cpv_pkg::state_t cur,
  output cpv_pkg::state_t      nxt,
  output logic                 done,
  output cpv_pkg::result_t     res
);

  cpv_pkg::state_t txt;
  cpv_pkg::state_t upd;
  logic [20:0]     cp_acc;

  assign cp_acc = {cur.partial_codepoint[14:0], data_byte[5:0]};

  // UTF-8 decoder step, used once the close code is complete
  always_comb begin
    txt = cur;
    if (!cur.text_bad) begin
      if (cur.bytes_pending == 2'd0) begin
        if (!data_byte[7]) begin
          txt = cur;
        end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
          txt.partial_codepoint = {16'd0, data_byte[4:0]};
          txt.bytes_pending     = 2'd1;
          txt.minimum_class     = cpv_pkg::MINC_2B;
        end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
          txt.partial_codepoint = {17'd0, data_byte[3:0]};
          txt.bytes_pending     = 2'd2;
          txt.minimum_class     = cpv_pkg::MINC_3B;
        end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
          txt.partial_codepoint = {18'd0, data_byte[2:0]};
          txt.bytes_pending     = 2'd3;
          txt.minimum_class     = cpv_pkg::MINC_4B;
        end else begin
          txt.text_bad = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        txt.text_bad = 1'b1;
      end else begin
        txt.partial_codepoint = cp_acc;
        txt.bytes_pending     = cur.bytes_pending - 2'd1;
        if (cur.bytes_pending == 2'd1) begin
          if (cp_acc < cpv_pkg::class_min(cur.minimum_class) || cp_acc > cpv_pkg::CP_MAX ||
              (cp_acc >= cpv_pkg::SURR_LO && cp_acc <= cpv_pkg::SURR_HI)) begin
            txt.text_bad = 1'b1;
          end
          txt.partial_codepoint = '0;
          txt.minimum_class     = cpv_pkg::MINC_NONE;
        end
      end
    end
  end

  // close code collection, then the text path
  always_comb begin
    upd = cur;
    if (!empty_payload) begin
      case (cur.byte_position)
        2'd0: begin
          upd.code_value    = {data_byte, 8'd0};
          upd.byte_position = 2'd1;
        end
        2'd1: begin
          upd.code_value    = {cur.code_value[15:8], data_byte};
          upd.code_bad      = !cpv_pkg::code_allowed({cur.code_value[15:8], data_byte});
          upd.byte_position = 2'd2;
        end
        default: begin
          upd = txt;
        end
      endcase
    end
  end

  assign done = empty_payload || last_byte;
  assign nxt  = done ? cpv_pkg::STATE_RESET : upd;

  always_comb begin
    res.status       = cpv_pkg::STATUS_OK;
    res.code_present = 1'b0;
    res.close_code   = 16'd0;
    if (upd.byte_position == 2'd1) begin
      res.status = cpv_pkg::STATUS_PROTO_ERR;
    end else if (upd.byte_position != 2'd0) begin
      res.code_present = 1'b1;
      res.close_code   = upd.code_value;
      if (upd.code_bad) begin
        res.status = cpv_pkg::STATUS_PROTO_ERR;
      end else if (upd.text_bad || upd.bytes_pending != 2'd0) begin
        res.status = cpv_pkg::STATUS_DATA_ERR;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/close_payload_validator_core.sv =====
// Close frame payload validator.
// Input channel (in_valid/in_ready): one item per payload byte, in order.
//   in_last_byte marks the final byte; in_empty_payload marks a payload
//   with no bytes (or ends one early) and counts as last on its own.
// Result channel (out_valid/out_ready): exactly one item per payload, after
//   its last item: out_status 0 ok, 1 protocol error (one-byte payload or
//   close code outside 1000-1003, 1007-1014, 3000-4999), 2 bad UTF-8 after
//   the code; out_code_present and out_close_code report the code.
// Throughput: one item per cycle while no last item is blocked. Every item
//   lands in an input register; from there a single short pass updates the
//   code/UTF-8 state and, on a last item, loads the result register.
// Output: out_valid and the result fields come straight from the result
//   register, which a last item loads as it leaves the input register.
// Stall: while a result waits on out_ready, items that give no result keep
//   flowing; a last item waits in the input register and in_ready drops
//   only once that register is occupied and blocked.
// Reset (rst_n low, synchronous): decoder state goes to its idle value and
//   both registers empty; no result is held over.
`default_nettype none
module close_payload_validator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_empty_payload,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_code_present,
  output logic [15:0]      out_close_code
);

  // input register
  logic        iv_r;
  logic [7:0]  idata_r;
  logic        iempty_r;
  logic        ilast_r;

  // decoder state, result register
  cpv_pkg::state_t  st_r;
  cpv_pkg::state_t  st_nxt;
  cpv_pkg::result_t res_nxt;
  cpv_pkg::result_t res_r;
  logic             ov_r;
  logic             done;

  logic out_free;
  logic advance;

  cpv_step u_step (
    .data_byte     (idata_r),
    .empty_payload (iempty_r),
    .last_byte     (ilast_r),
    .cur           (st_r),
    .nxt           (st_nxt),
    .done          (done),
    .res           (res_nxt)
  );

  // an item without a result never waits on the output side
  assign out_free = !ov_r || out_ready;
  assign advance  = iv_r && (!done || out_free);
  assign in_ready = !iv_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
      st_r <= cpv_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        iv_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && done) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idata_r  <= in_data_byte;
      iempty_r <= in_empty_payload;
      ilast_r  <= in_last_byte;
    end
    if (advance && done) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = res_r.status;
  assign out_code_present = res_r.code_present;
  assign out_close_code   = res_r.close_code;

endmodule
`default_nettype wire

// ===== rtl/cpv_checker.sv =====
`default_nettype none
`include "close_payload_validator_core_assert.svh"
module cpv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic        out_code_present,
  input wire logic [15:0] out_close_code
);

  logic [18:0] res_bits;
  logic        no_code_ok;
  logic        code_1000;

  assign res_bits   = {out_status, out_code_present, out_close_code};
  assign no_code_ok = (out_close_code == 16'd0) && (out_status != cpv_pkg::STATUS_DATA_ERR);
  assign code_1000  = out_code_present && (out_close_code == 16'd1000);

  // a held result keeps its verdict
  `CPV_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(res_bits))
  `CPV_ASSERT_IMP(a_status_code, out_valid, out_status != 2'd3)
  // no code means zero code and never a data error
  `CPV_ASSERT_IMP(a_no_code, out_valid && !out_code_present, no_code_ok)
  // code 1000, an allowed code, can not be a protocol error
  `CPV_ASSERT_IMP(a_good_code, out_valid && code_1000, out_status != cpv_pkg::STATUS_PROTO_ERR)

endmodule

bind close_payload_validator_core cpv_checker u_cpv_checker (.*);
`default_nettype wire

// ===== test/close_payload_validator_core_test.sv =====
`timescale 1ns / 100ps

module close_payload_validator_core_test;
  import cpv_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int PHASE_LEN   = ITEM_TARGET / 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  // one payload item as it goes over the input channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       empty_payload;
    logic       last_byte;
  } payload_item_t;

  // kinds of UTF-8 damage planted in the text part
  typedef enum int {
    FAULT_OVERLONG,
    FAULT_SURROGATE,
    FAULT_TOO_BIG,
    FAULT_STRAY_CONT,
    FAULT_BAD_LEAD,
    FAULT_CUT_SHORT,
    FAULT_BROKEN_CONT
  } fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_empty_payload = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_code_present;
  logic [15:0] out_close_code;

  close_payload_validator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_empty_payload (in_empty_payload),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_code_present (out_code_present),
    .out_close_code   (out_close_code)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------
  // Stimulus store and expected close results
  // ---------------------------------------------------------------
  payload_item_t pending_items[$];
  result_t       expected_results[$];
  logic [7:0]    payload_q[$];     // bytes of the payload being built

  // close codes right at and next to the allowed range limits
  logic [15:0] code_edges [12] = '{16'd999, 16'd1000, 16'd1003, 16'd1004, 16'd1006,
                                   16'd1007, 16'd1014, 16'd1015, 16'd2999, 16'd3000,
                                   16'd4999, 16'd5000};

  int accepted_count = 0;
  int result_count = 0;
  int ok_count = 0;
  int proto_count = 0;
  int data_count = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int holds_done = 0;

  // ---------------------------------------------------------------
  // Predictor: close code collector plus strict UTF-8 decoder
  // ---------------------------------------------------------------
  logic [1:0]  pos_seen = 2'd0;        // payload bytes seen, saturates at 2
  logic [15:0] code_acc = 16'd0;       // big-endian close code
  logic        code_rejected = 1'b0;
  logic [20:0] cp_acc = 21'd0;         // code point being assembled
  logic [1:0]  cont_left = 2'd0;       // continuation bytes still owed
  logic [1:0]  lead_class = MINC_NONE; // sets the overlong floor
  logic        utf8_broken = 1'b0;     // sticky until the payload ends

  function automatic void clear_decoder();
    pos_seen      = 2'd0;
    code_acc      = 16'd0;
    code_rejected = 1'b0;
    cp_acc        = 21'd0;
    cont_left     = 2'd0;
    lead_class    = MINC_NONE;
    utf8_broken   = 1'b0;
  endfunction

  function automatic void utf8_feed(input logic [7:0] b);
    logic [20:0] floor_cp;
    if (utf8_broken) return;
    if (cont_left == 2'd0) begin
      if (b <= 8'h7F) return;
      if (b >= 8'hC2 && b <= 8'hDF) begin
        cp_acc = {16'd0, b[4:0]};
        cont_left = 2'd1;
        lead_class = MINC_2B;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cp_acc = {17'd0, b[3:0]};
        cont_left = 2'd2;
        lead_class = MINC_3B;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        cp_acc = {18'd0, b[2:0]};
        cont_left = 2'd3;
        lead_class = MINC_4B;
      end else begin
        utf8_broken = 1'b1;  // stray continuation, C0/C1, F5 and up
      end
      return;
    end
    if (b[7:6] != 2'b10) begin
      utf8_broken = 1'b1;
      return;
    end
    cp_acc = {cp_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left == 2'd0) begin
      case (lead_class)
        MINC_2B: floor_cp = 21'h000080;
        MINC_3B: floor_cp = 21'h000800;
        MINC_4B: floor_cp = 21'h010000;
        default: floor_cp = 21'h000000;
      endcase
      if (cp_acc < floor_cp || cp_acc > CP_MAX || (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
        utf8_broken = 1'b1;
      cp_acc = 21'd0;
      lead_class = MINC_NONE;
    end
  endfunction

  // payload done: queue its one close result, then start over
  function automatic void close_out();
    result_t r;
    r.status = STATUS_OK;
    r.code_present = 1'b0;
    r.close_code = 16'd0;
    if (pos_seen == 2'd1) begin
      r.status = STATUS_PROTO_ERR;
    end else if (pos_seen == 2'd2) begin
      r.code_present = 1'b1;
      r.close_code = code_acc;
      if (code_rejected) r.status = STATUS_PROTO_ERR;
      else if (utf8_broken || cont_left != 2'd0) r.status = STATUS_DATA_ERR;
    end
    expected_results.push_back(r);
    clear_decoder();
  endfunction

  function automatic void absorb_item(input logic [7:0] b, input logic empty, input logic last);
    if (empty) begin
      close_out();  // the empty mark wins over last_byte
      return;
    end
    case (pos_seen)
      2'd0: begin
        code_acc = {b, 8'h00};
        pos_seen = 2'd1;
      end
      2'd1: begin
        code_acc[7:0] = b;
        code_rejected = !((code_acc >= CODE_MIN_A && code_acc <= CODE_MAX_A) ||
                          (code_acc >= CODE_MIN_B && code_acc <= CODE_MAX_B) ||
                          (code_acc >= CODE_MIN_C && code_acc <= CODE_MAX_C));
        pos_seen = 2'd2;
      end
      default: utf8_feed(b);
    endcase
    if (last) close_out();
  endfunction

  // ---------------------------------------------------------------
  // Payload builders
  // ---------------------------------------------------------------
  task automatic push_cp(input logic [20:0] cp, input int nb);
    case (nb)
      1: payload_q.push_back({1'b0, cp[6:0]});
      2: begin
        payload_q.push_back({3'b110, cp[10:6]});
        payload_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        payload_q.push_back({4'b1110, cp[15:12]});
        payload_q.push_back({2'b10, cp[11:6]});
        payload_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        payload_q.push_back({5'b11110, cp[20:18]});
        payload_q.push_back({2'b10, cp[17:12]});
        payload_q.push_back({2'b10, cp[11:6]});
        payload_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_valid_char();
    int pick;
    logic [20:0] cp;
    pick = $urandom_range(0, 39);
    case (pick)
      0: push_cp(21'h00007F, 1);
      1: push_cp(21'h000080, 2);
      2: push_cp(21'h0007FF, 2);
      3: push_cp(21'h000800, 3);
      4: push_cp(21'h00D7FF, 3);
      5: push_cp(21'h00E000, 3);
      6: push_cp(21'h00FFFF, 3);
      7: push_cp(21'h010000, 4);
      8: push_cp(21'h10FFFF, 4);
      default: begin
        if (pick < 23) begin
          push_cp(21'($urandom_range(0, 'h7F)), 1);
        end else if (pick < 29) begin
          push_cp(21'($urandom_range('h80, 'h7FF)), 2);
        end else if (pick < 35) begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h5800;  // keep it legal
          push_cp(cp, 3);
        end else begin
          push_cp(21'($urandom_range('h10000, 'h10FFFF)), 4);
        end
      end
    endcase
  endtask

  task automatic add_fault();
    fault_t kind;
    int nb;
    int pick;
    kind = fault_t'($urandom_range(0, 6));
    nb = $urandom_range(2, 4);
    pick = $urandom_range(0, 12);
    case (kind)
      FAULT_OVERLONG:
        push_cp(21'($urandom_range(0, nb == 2 ? 'h7F : nb == 3 ? 'h7FF : 'hFFFF)), nb);
      FAULT_SURROGATE:
        push_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
      FAULT_TOO_BIG:
        push_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      FAULT_STRAY_CONT:
        payload_q.push_back(8'($urandom_range('h80, 'hBF)));
      FAULT_BAD_LEAD:
        payload_q.push_back(pick < 2 ? 8'(8'hC0 + pick) : 8'(8'hF3 + pick));
      FAULT_CUT_SHORT: begin
        // legal sequence with its tail dropped
        push_cp(21'(nb == 2 ? $urandom_range('h80, 'h7FF) :
                    nb == 3 ? $urandom_range('h800, 'hD7FF) :
                              $urandom_range('h10000, 'h10FFFF)), nb);
        repeat ($urandom_range(1, nb - 1)) void'(payload_q.pop_back());
      end
      default: begin
        payload_q.push_back(8'($urandom_range('hC2, 'hF4)));
        payload_q.push_back(8'($urandom_range(0, 'h7F)));
      end
    endcase
  endtask

  // text after the code; a fault slot equal to nchars lands at the very end
  task automatic add_text(input int nchars, input bit faulty);
    int fault_at;
    fault_at = faulty ? $urandom_range(0, nchars) : -1;
    for (int i = 0; i <= nchars; i++) begin
      if (i == fault_at) add_fault();
      if (i < nchars) add_valid_char();
    end
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom_range(1000, 1003));
      2, 3:    return 16'($urandom_range(1007, 1014));
      4, 5:    return 16'($urandom_range(3000, 4999));
      6, 7:    return code_edges[$urandom_range(0, 11)];
      default: return 16'($urandom);
    endcase
  endfunction

  // turn payload_q into items; an empty mark either ends it or stands alone
  task automatic emit_payload(input bit end_with_mark, input bit mark_last);
    int n;
    n = payload_q.size();
    for (int i = 0; i < n; i++)
      pending_items.push_back('{payload_q[i], 1'b0, (i == n - 1) && !end_with_mark});
    if (end_with_mark || n == 0)
      pending_items.push_back('{8'($urandom), 1'b1, mark_last});
    payload_q.delete();
  endtask

  // ---------------------------------------------------------------
  // Idle rates: sender 22 / receiver 57, then swapped, then none
  // ---------------------------------------------------------------
  function automatic int send_idle_pct();
    if (accepted_count < PHASE_LEN) return 22;
    if (accepted_count < 2 * PHASE_LEN) return 57;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_count < PHASE_LEN) return 57;
    if (accepted_count < 2 * PHASE_LEN) return 22;
    return 0;
  endfunction

  // ---------------------------------------------------------------
  // Driver: predicts on acceptance, then offers the next item
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    payload_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_item(in_data_byte, in_empty_payload, in_last_byte);
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        // no sender gaps while the receiver is held off: keep the block filling
        if (pending_items.size() != 0 &&
            (hold_left != 0 || $urandom_range(0, 99) >= send_idle_pct())) begin
          nxt = pending_items.pop_front();
          in_valid         <= 1'b1;
          in_data_byte     <= nxt.data_byte;
          in_empty_payload <= nxt.empty_payload;
          in_last_byte     <= nxt.last_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Receiver ready, with two long hold-offs
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && accepted_count >= 300) ||
                 (holds_done == 1 && accepted_count >= 1400)) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // ---------------------------------------------------------------
  // Monitor: in-order compare against the predicted close results
  // ---------------------------------------------------------------
  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d present %0d code %0d",
                             out_status, out_code_present, out_close_code));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_code_present !== want.code_present ||
            out_close_code !== want.close_code)
          flag_error($sformatf(
            "result %0d mismatch: status %0d/%0d present %0d/%0d code %0d/%0d (exp/got)",
            result_count, want.status, out_status, want.code_present, out_code_present,
            want.close_code, out_close_code));
        case (want.status)
          STATUS_OK:        ok_count++;
          STATUS_PROTO_ERR: proto_count++;
          default:          data_count++;
        endcase
      end
      result_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d items accepted, %0d results pending",
               accepted_count, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    int shape;
    bit end_mark;
    logic [15:0] close_val;

    // directed: empty payloads, one-byte payload, code limits, UTF-8 corners
    emit_payload(1'b1, 1'b0);                     // empty mark alone
    emit_payload(1'b1, 1'b1);                     // empty mark also flagged last
    payload_q = '{8'h03};
    emit_payload(1'b0, 1'b0);                     // one byte: protocol error
    payload_q = '{8'h03, 8'hE8};
    emit_payload(1'b0, 1'b0);                     // code 1000, no text
    payload_q = '{8'h13, 8'h87, 8'hF0, 8'h9F, 8'h98, 8'h80};
    emit_payload(1'b0, 1'b0);                     // code 4999, four-byte char
    payload_q = '{8'hFF, 8'hFF, 8'hC0};
    emit_payload(1'b0, 1'b0);                     // bad code outranks bad lead byte
    payload_q = '{8'h0B, 8'hB8, 8'hED, 8'hA0, 8'h80};
    emit_payload(1'b0, 1'b0);                     // code 3000, surrogate
    payload_q = '{8'h03, 8'hF2, 8'hE2};
    emit_payload(1'b1, 1'b1);                     // early empty mark, sequence open
    payload_q = '{8'h00};
    emit_payload(1'b1, 1'b0);                     // early empty mark after one byte

    // random: mostly code plus text, some damaged, some short or noisy
    while (pending_items.size() < ITEM_TARGET) begin
      shape = $urandom_range(0, 99);
      end_mark = ($urandom_range(0, 6) == 0);
      if (shape < 4) begin
        // no bytes: emit_payload sends the lone empty mark
      end else if (shape < 9) begin
        payload_q.push_back(8'($urandom));
      end else if (shape < 16) begin
        repeat ($urandom_range(1, 10)) payload_q.push_back(8'($urandom));
      end else begin
        close_val = pick_code();
        payload_q.push_back(close_val[15:8]);
        payload_q.push_back(close_val[7:0]);
        add_text($urandom_range(0, 8), $urandom_range(0, 3) == 0);
      end
      emit_payload(end_mark, 1'($urandom_range(0, 1)));
    end

    clear_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so all posedge traffic has settled
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (10) @(negedge clk);

    if (expected_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("run covered %0d items and %0d close results: %0d ok, %0d protocol, %0d data",
             accepted_count, result_count, ok_count, proto_count, data_count);
    $display("three idle phases, %0d long output hold-offs, %0d failures",
             holds_done, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
